// ===== design/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Buddy page allocator package
// Field widths, operation and status codes, and the controller state type.
// ----------------------------------------------------------------------------
package bpa_pkg;

	localparam int FUNC_W     = 1;
	localparam int REQ_SIZE_W = 11;
	localparam int OFFSET_W   = 10;
	localparam int STATUS_W   = 2;
	localparam int PAGES_W    = 11;
	localparam int CFG_W      = 4;

	localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
	localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_START,
		ST_ROOT,
		ST_DESC,
		ST_FCHK,
		ST_ASC,
		ST_FIN
	} bpa_state_t;

endpackage

// ===== design/bpa_if.sv =====
// ----------------------------------------------------------------------------
// Buddy page allocator channels
// Request, response and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface bpa_req_if;
	logic                          valid;
	logic                          ready;
	logic [bpa_pkg::FUNC_W-1:0]     func;
	logic [bpa_pkg::REQ_SIZE_W-1:0] request_size;
	logic [bpa_pkg::OFFSET_W-1:0]   block_offset;

	modport source (output valid, func, request_size, block_offset, input ready);
	modport sink (input valid, func, request_size, block_offset, output ready);
endinterface

interface bpa_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [bpa_pkg::STATUS_W-1:0] status;
	logic [bpa_pkg::OFFSET_W-1:0] granted_offset;
	logic [bpa_pkg::PAGES_W-1:0]  pages_free;

	modport source (output valid, status, granted_offset, pages_free, input ready);
	modport sink (input valid, status, granted_offset, pages_free, output ready);
endinterface

interface bpa_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [bpa_pkg::CFG_W-1:0] pool_size_log2;

	modport source (output valid, pool_size_log2, input ready);
	modport sink (input valid, pool_size_log2, output ready);
endinterface

// ===== design/buddy_page_allocator.sv =====
// ----------------------------------------------------------------------------
// Buddy page allocator
// Allocates and frees power-of-two page blocks using a tree of largest free
// block sizes held in an on-chip memory.
// ----------------------------------------------------------------------------
// Usage: an item on req either allocates (func 0) a block of request_size
// pages, rounded up to a power of two, or frees the block at block_offset.
// One response item on rsp carries the status, the granted offset and the
// number of free pages left. The cfg channel writes the pool size; it is
// always ready and starts a rebuild of the tree.
// Items are handled one at a time. The tree memory is walked one level per
// cycle: an allocate goes down from the root and then back up, and a free
// goes only up. A refused allocate, or one of the whole pool, answers
// straight after the root read, and a free that fails its range checks
// answers without reading the tree. The next item can be accepted in the
// same cycle in which the response item appears.
// After reset, and after every pool size write, a rebuild pass writes nodes 1
// to 2P-1 for a pool of P pages, one per cycle, with req held not ready.
// The response sits in an output register; while the receiver stalls, the
// next item is still accepted and processed, and only its response waits.
// ----------------------------------------------------------------------------
module buddy_page_allocator #(
	parameter int MAX_POOL_PAGES = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	bpa_req_if.sink         req,
	bpa_rsp_if.source       rsp,
	bpa_cfg_if.sink         cfg
);
	import bpa_pkg::*;

	localparam int ML     = $clog2(MAX_POOL_PAGES + 1) - 1;
	localparam int VW     = ML + 1;
	localparam int IW     = ML + 1;
	localparam int CW     = (VW > 12) ? VW : 12;
	localparam int LG_W   = $clog2(ML + 1);
	localparam int LW     = (LG_W > 4) ? LG_W : 4;
	localparam int TREE_N = 2 ** IW;
	localparam int RST_LG = (ML < 10) ? ML : 10;

	function automatic logic [LW-1:0] ceil_log2(input logic [REQ_SIZE_W-1:0] x);
		logic [REQ_SIZE_W-1:0] y;
		logic [LW-1:0]         lg;
		y  = x - 1'b1;
		lg = '0;
		for (int i = 0; i < REQ_SIZE_W; i++) begin
			if (y[i]) begin
				lg = LW'(i + 1);
			end
		end
		if (x <= REQ_SIZE_W'(1)) begin
			lg = '0;
		end
		return lg;
	endfunction

	// Tree memory: node 1 is the root, node i has children 2i and 2i+1.
	logic [VW-1:0] tree_mem [TREE_N];
	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	logic [VW-1:0] mem_wdata;
	logic          rd_a_en, rd_b_en;
	logic [IW-1:0] rd_a_addr, rd_b_addr;
	logic [VW-1:0] rd_a_q, rd_b_q;

	bpa_state_t state_q, state_d;
	logic [LW-1:0] pool_lg_q, pool_lg_d;
	logic [VW-1:0] count_q, count_d;
	logic [IW-1:0] clr_idx_q, clr_idx_d;
	logic [LW-1:0] clr_lg_q, clr_lg_d;
	logic          out_valid_q, out_valid_d;

	logic [FUNC_W-1:0]   func_q, func_d;
	logic [LW-1:0]       slg_q, slg_d;
	logic [OFFSET_W-1:0] off_q, off_d;
	logic [IW-1:0]       idx_q, idx_d;
	logic [LW-1:0]       lg_q, lg_d;
	logic [VW-1:0]       val_q, val_d;
	logic [STATUS_W-1:0] status_q, status_d;
	logic [OFFSET_W-1:0] granted_q, granted_d;
	logic [STATUS_W-1:0] out_status_q;
	logic [OFFSET_W-1:0] out_granted_q;
	logic [PAGES_W-1:0]  out_free_q;

	logic [VW-1:0] pool_pages;
	logic [CW-1:0] size_c;
	logic          free_bad;
	logic [IW-1:0] free_idx;
	logic          l_fits, r_fits, pick_right;
	logic [IW-1:0] cidx;
	logic [LW-1:0] clg;
	logic [CW-1:0] psize;
	logic [CW:0]   pair_sum;
	logic [CW-1:0] pmax, pval;
	logic [IW-1:0] parent;
	logic [CW:0]   count_sum;
	logic [LW-1:0] cfg_lg;

	assign req.ready  = (state_q == ST_IDLE);
	assign cfg.ready  = 1'b1;
	assign rsp.valid  = out_valid_q;
	assign rsp.status = out_status_q;
	assign rsp.granted_offset = out_granted_q;
	assign rsp.pages_free     = out_free_q;

	assign pool_pages = VW'(1) << pool_lg_q;
	assign size_c     = CW'(1) << slg_q;

	assign free_bad = (slg_q > pool_lg_q)
		|| ((CW'(off_q) & (size_c - 1'b1)) != '0)
		|| (((CW + 1)'(off_q) + (CW + 1)'(size_c)) > (CW + 1)'(pool_pages));
	assign free_idx = IW'(((CW + 1)'(pool_pages) + (CW + 1)'(off_q)) >> slg_q);

	// Descent choice: both children fit takes the smaller, left on a tie.
	assign l_fits     = (CW'(rd_a_q) >= size_c);
	assign r_fits     = (CW'(rd_b_q) >= size_c);
	assign pick_right = l_fits ? (r_fits && (rd_a_q > rd_b_q)) : 1'b1;
	assign cidx       = {idx_q[IW-2:0], pick_right};
	assign clg        = lg_q - 1'b1;

	// Ascent merge: the parent is whole again when both halves are wholly free.
	assign psize    = CW'(1) << (lg_q + 1'b1);
	assign pair_sum = (CW + 1)'(val_q) + (CW + 1)'(rd_b_q);
	assign pmax     = (val_q > rd_b_q) ? CW'(val_q) : CW'(rd_b_q);
	assign pval     = (pair_sum == (CW + 1)'(psize)) ? psize : pmax;
	assign parent   = idx_q >> 1;

	assign count_sum = (CW + 1)'(count_q) + (CW + 1)'(size_c);
	assign cfg_lg    = (LW'(cfg.pool_size_log2) > LW'(ML)) ? LW'(ML)
		: LW'(cfg.pool_size_log2);

	always_comb begin
		state_d     = state_q;
		pool_lg_d   = pool_lg_q;
		count_d     = count_q;
		clr_idx_d   = clr_idx_q;
		clr_lg_d    = clr_lg_q;
		out_valid_d = out_valid_q && !rsp.ready;
		func_d      = func_q;
		slg_d       = slg_q;
		off_d       = off_q;
		idx_d       = idx_q;
		lg_d        = lg_q;
		val_d       = val_q;
		status_d    = status_q;
		granted_d   = granted_q;
		mem_we      = 1'b0;
		mem_waddr   = '0;
		mem_wdata   = '0;
		rd_a_en     = 1'b0;
		rd_a_addr   = '0;
		rd_b_en     = 1'b0;
		rd_b_addr   = '0;

		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_idx_q;
				mem_wdata = VW'(1) << clr_lg_q;
				// The last node of a level is all ones; the next one starts the level below.
				if ((clr_idx_q & (clr_idx_q + 1'b1)) == '0) begin
					if (clr_lg_q == '0) begin
						state_d = ST_IDLE;
					end else begin
						clr_lg_d = clr_lg_q - 1'b1;
					end
				end
				clr_idx_d = clr_idx_q + 1'b1;
			end
			ST_IDLE: begin
				if (req.valid) begin
					func_d  = req.func;
					slg_d   = ceil_log2(req.request_size);
					off_d   = req.block_offset;
					state_d = ST_START;
				end
			end
			ST_START: begin
				granted_d = '0;
				if (func_q == FUNC_ALLOC) begin
					rd_a_en   = 1'b1;
					rd_a_addr = IW'(1);
					state_d   = ST_ROOT;
				end else if (free_bad) begin
					status_d = STATUS_BAD_FREE;
					state_d  = ST_FIN;
				end else begin
					rd_a_en   = 1'b1;
					rd_a_addr = free_idx;
					rd_b_en   = 1'b1;
					rd_b_addr = free_idx ^ IW'(1);
					idx_d     = free_idx;
					state_d   = ST_FCHK;
				end
			end
			ST_ROOT: begin
				if (CW'(rd_a_q) < size_c) begin
					status_d = STATUS_NO_SPACE;
					state_d  = ST_FIN;
				end else if (slg_q == pool_lg_q) begin
					mem_we    = 1'b1;
					mem_waddr = IW'(1);
					count_d   = (CW'(count_q) >= size_c) ? VW'(CW'(count_q) - size_c) : '0;
					status_d  = STATUS_DONE;
					state_d   = ST_FIN;
				end else begin
					rd_a_en   = 1'b1;
					rd_a_addr = IW'(2);
					rd_b_en   = 1'b1;
					rd_b_addr = IW'(3);
					idx_d     = IW'(1);
					lg_d      = pool_lg_q;
					state_d   = ST_DESC;
				end
			end
			ST_DESC: begin
				idx_d = cidx;
				lg_d  = clg;
				if (clg == slg_q) begin
					mem_we    = 1'b1;
					mem_waddr = cidx;
					rd_b_en   = 1'b1;
					rd_b_addr = cidx ^ IW'(1);
					val_d     = '0;
					count_d   = (CW'(count_q) >= size_c) ? VW'(CW'(count_q) - size_c) : '0;
					status_d  = STATUS_DONE;
					granted_d = OFFSET_W'(IW'(cidx << slg_q) - IW'(pool_pages));
					state_d   = ST_ASC;
				end else begin
					rd_a_en   = 1'b1;
					rd_a_addr = {cidx[IW-2:0], 1'b0};
					rd_b_en   = 1'b1;
					rd_b_addr = {cidx[IW-2:0], 1'b1};
				end
			end
			ST_FCHK: begin
				if (rd_a_q != '0) begin
					status_d = STATUS_BAD_FREE;
					state_d  = ST_FIN;
				end else begin
					mem_we    = 1'b1;
					mem_waddr = idx_q;
					mem_wdata = VW'(size_c);
					count_d   = (count_sum > (CW + 1)'(pool_pages)) ? pool_pages
						: VW'(count_sum);
					status_d  = STATUS_DONE;
					val_d     = VW'(size_c);
					lg_d      = slg_q;
					// The sibling read issued at the start is still held on port B.
					state_d   = (idx_q == IW'(1)) ? ST_FIN : ST_ASC;
				end
			end
			ST_ASC: begin
				mem_we    = 1'b1;
				mem_waddr = parent;
				mem_wdata = VW'(pval);
				idx_d     = parent;
				val_d     = VW'(pval);
				lg_d      = lg_q + 1'b1;
				if (parent == IW'(1)) begin
					state_d = ST_FIN;
				end else begin
					rd_b_en   = 1'b1;
					rd_b_addr = parent ^ IW'(1);
				end
			end
			ST_FIN: begin
				if (!out_valid_q || rsp.ready) begin
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (cfg.valid) begin
			pool_lg_d = cfg_lg;
			count_d   = VW'(1) << cfg_lg;
			clr_idx_d = IW'(1);
			clr_lg_d  = cfg_lg;
			state_d   = ST_CLEAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			pool_lg_q   <= LW'(RST_LG);
			count_q     <= VW'(1) << RST_LG;
			clr_idx_q   <= IW'(1);
			clr_lg_q    <= LW'(RST_LG);
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			pool_lg_q   <= pool_lg_d;
			count_q     <= count_d;
			clr_idx_q   <= clr_idx_d;
			clr_lg_q    <= clr_lg_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		func_q    <= func_d;
		slg_q     <= slg_d;
		off_q     <= off_d;
		idx_q     <= idx_d;
		lg_q      <= lg_d;
		val_q     <= val_d;
		status_q  <= status_d;
		granted_q <= granted_d;
		if (state_q == ST_FIN && (!out_valid_q || rsp.ready)) begin
			out_status_q  <= status_q;
			out_granted_q <= granted_q;
			out_free_q    <= PAGES_W'(count_q);
		end
	end

	// Within one item a cycle never reads the entry it writes, so no bypass is needed.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			tree_mem[mem_waddr] <= mem_wdata;
		end
		if (rd_a_en) begin
			rd_a_q <= tree_mem[rd_a_addr];
		end
		if (rd_b_en) begin
			rd_b_q <= tree_mem[rd_b_addr];
		end
	end

endmodule

// ===== sim/bpa_reply_checker.sv =====
// ----------------------------------------------------------------------------
// Buddy page allocator response checker
// Watches the request, response and pool size channels, keeps its own copy of
// the largest-free tree and the free page count, predicts the response to
// every accepted request item and compares each response item against it.
// ----------------------------------------------------------------------------
module bpa_reply_checker #(
	parameter int MAX_POOL_PAGES = 1024
) (
	input  logic clk,
	input  logic arst_n,
	bpa_req_if   req,
	bpa_rsp_if   rsp,
	bpa_cfg_if   cfg,
	output int   mismatches,
	output int   awaiting,
	output int   n_granted,
	output int   n_refused,
	output int   n_rejected
);
	import bpa_pkg::*;

	localparam int LOG2_MAX   = $clog2(MAX_POOL_PAGES + 1) - 1;
	localparam int NODE_W     = LOG2_MAX + 1;
	localparam int RESET_LOG2 = 10;
	localparam int SHOWN_MAX  = 10;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [OFFSET_W-1:0] offset;
		logic [PAGES_W-1:0]  pages;
	} alloc_reply_t;

	alloc_reply_t      reply_q[$];
	logic [NODE_W-1:0] largest_free [0:2*MAX_POOL_PAGES-1];
	int unsigned       pool_pages;
	int unsigned       spare_pages;

	function automatic void rebuild(input logic [CFG_W-1:0] lg);
		int unsigned eff;
		eff = (lg > LOG2_MAX) ? LOG2_MAX : lg;
		pool_pages = 1 << eff;
		foreach (largest_free[i])
			largest_free[i] = '0;
		// Every node at depth d covers pool_pages >> d pages.
		for (int unsigned lvl = 0; lvl <= eff; lvl++)
			for (int unsigned n = 1 << lvl; n < (2 << lvl); n++)
				largest_free[n] = NODE_W'(pool_pages >> lvl);
		spare_pages = pool_pages;
	endfunction

	function automatic int unsigned pow2_ceil(input logic [REQ_SIZE_W-1:0] asked);
		int unsigned r;
		r = 1;
		while (r < asked)
			r <<= 1;
		return r;
	endfunction

	function automatic alloc_reply_t serve(input logic [FUNC_W-1:0] op,
			input logic [REQ_SIZE_W-1:0] asked, input logic [OFFSET_W-1:0] where);
		alloc_reply_t rep;
		int unsigned  sz, idx, span, lft, rgt, off;
		rep = '{status: STATUS_DONE, offset: '0, pages: '0};
		sz = pow2_ceil(asked);
		off = where;
		if (op == FUNC_ALLOC) begin
			if (largest_free[1] < sz) begin
				rep.status = STATUS_NO_SPACE;
			end else begin
				idx = 1;
				span = pool_pages;
				// Best fit on the way down: the tighter child wins, left on a tie.
				while (span > sz) begin
					lft = largest_free[2*idx];
					rgt = largest_free[2*idx+1];
					if (lft >= sz && (rgt < sz || lft <= rgt))
						idx = 2 * idx;
					else
						idx = 2 * idx + 1;
					span >>= 1;
				end
				largest_free[idx] = '0;
				rep.offset = OFFSET_W'(idx * span - pool_pages);
				while (idx > 1) begin
					idx >>= 1;
					lft = largest_free[2*idx];
					rgt = largest_free[2*idx+1];
					largest_free[idx] = NODE_W'((lft > rgt) ? lft : rgt);
				end
				spare_pages = (spare_pages >= sz) ? spare_pages - sz : 0;
			end
		end else begin
			if (sz > pool_pages || (off & (sz - 1)) != 0 || off + sz > pool_pages) begin
				rep.status = STATUS_BAD_FREE;
			end else begin
				idx = (pool_pages + off) / sz;
				if (largest_free[idx] != 0) begin
					rep.status = STATUS_BAD_FREE;
				end else begin
					largest_free[idx] = NODE_W'(sz);
					span = sz;
					// Two wholly free halves merge back into one full block.
					while (idx > 1) begin
						idx >>= 1;
						span <<= 1;
						lft = largest_free[2*idx];
						rgt = largest_free[2*idx+1];
						if (lft + rgt == span)
							largest_free[idx] = NODE_W'(span);
						else
							largest_free[idx] = NODE_W'((lft > rgt) ? lft : rgt);
					end
					spare_pages = spare_pages + sz;
					if (spare_pages > pool_pages)
						spare_pages = pool_pages;
				end
			end
		end
		rep.pages = PAGES_W'(spare_pages);
		return rep;
	endfunction

	task automatic report(input string text);
		mismatches++;
		if (mismatches <= SHOWN_MAX)
			$display("[%0t] mismatch: %s", $realtime, text);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		alloc_reply_t want;
		alloc_reply_t seen;
		if (!arst_n) begin
			reply_q.delete();
			rebuild(CFG_W'(RESET_LOG2));
			mismatches = 0;
			awaiting   = 0;
			n_granted  = 0;
			n_refused  = 0;
			n_rejected = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				seen = '{status: rsp.status, offset: rsp.granted_offset,
					pages: rsp.pages_free};
				if (reply_q.size() == 0) begin
					report($sformatf({"response item with none expected:",
						" status %0d offset %0d pages %0d"},
						seen.status, seen.offset, seen.pages));
				end else begin
					want = reply_q.pop_front();
					if (seen != want)
						report($sformatf({"status %0d/%0d offset %0d/%0d pages %0d/%0d",
							" (expected/actual)"}, want.status, seen.status,
							want.offset, seen.offset, want.pages, seen.pages));
				end
			end
			if (cfg.valid && cfg.ready)
				rebuild(cfg.pool_size_log2);
			if (req.valid && req.ready) begin
				want = serve(req.func, req.request_size, req.block_offset);
				case (want.status)
					STATUS_DONE:     if (req.func == FUNC_ALLOC) n_granted++;
					STATUS_NO_SPACE: n_refused++;
					default:         n_rejected++;
				endcase
				reply_q.push_back(want);
			end
			awaiting = reply_q.size();
		end
	end

endmodule

// ===== sim/buddy_page_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// Buddy page allocator testbench
// Drives allocate and free request items over several pool sizes, first a
// directed set of edge cases and then random traffic of mostly allocates, in
// which most frees name blocks that were really granted, with random idling
// on both channels. The checker beside the block predicts and compares
// every response item.
module buddy_page_allocator_tb;
	import bpa_pkg::*;

	localparam int MAX_PAGES   = 1024;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 40;

	typedef struct {
		logic [FUNC_W-1:0]     func;
		logic [REQ_SIZE_W-1:0] size;
	} issued_t;

	typedef struct {
		logic [REQ_SIZE_W-1:0] size;
		logic [OFFSET_W-1:0]   offset;
	} held_t;

	logic clk;
	logic arst_n;
	int   mismatches, awaiting, n_granted, n_refused, n_rejected;
	int   cycle_count = 0;
	bit   quiet;
	int   pool_pages;
	int   pools_written;

	issued_t issued_q[$];
	held_t   held_q[$];

	bpa_req_if req_ch();
	bpa_rsp_if rsp_ch();
	bpa_cfg_if cfg_ch();

	buddy_page_allocator #(
		.MAX_POOL_PAGES(MAX_PAGES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	bpa_reply_checker #(
		.MAX_POOL_PAGES(MAX_PAGES)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch),
		.mismatches(mismatches),
		.awaiting(awaiting),
		.n_granted(n_granted),
		.n_refused(n_refused),
		.n_rejected(n_rejected)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timed out after %0d cycles with %0d responses outstanding",
				cycle_count, awaiting);
			$display("end of test: mismatches");
			$finish;
		end
	end

	always @(negedge clk)
		rsp_ch.ready <= !(!quiet && $urandom_range(0, 99) < 11);

	// Granted blocks are remembered so that most frees name a real block.
	always @(posedge clk) begin : track_grants
		issued_t done_item;
		if (rsp_ch.valid && rsp_ch.ready && issued_q.size() != 0) begin
			done_item = issued_q.pop_front();
			if (done_item.func == FUNC_ALLOC && rsp_ch.status == STATUS_DONE)
				held_q.push_back('{done_item.size, rsp_ch.granted_offset});
		end
		if (req_ch.valid && req_ch.ready)
			issued_q.push_back('{req_ch.func, req_ch.request_size});
	end

	task automatic send(input logic [FUNC_W-1:0] op, input int size, input int offset);
		if (!quiet && $urandom_range(0, 99) < 11) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.func         <= op;
		req_ch.request_size <= REQ_SIZE_W'(size);
		req_ch.block_offset <= OFFSET_W'(offset);
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		@(negedge clk);
		while (awaiting != 0)
			@(negedge clk);
	endtask

	task automatic set_pool(input int lg);
		drain();
		held_q.delete();
		cfg_ch.valid          <= 1'b1;
		cfg_ch.pool_size_log2 <= CFG_W'(lg);
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		pool_pages = 1 << ((lg > $clog2(MAX_PAGES)) ? $clog2(MAX_PAGES) : lg);
		pools_written++;
	endtask

	function automatic int pick_alloc_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, (pool_pages >= 16) ? pool_pages / 16 : 1);
		else if (r < 92)
			return $urandom_range(0, pool_pages);
		return $urandom_range(0, 2047);
	endfunction

	task automatic random_items(input int count, input int quiet_from, input int quiet_to);
		int    pick, sz, sel;
		held_t blk;
		for (int k = 0; k < count; k++) begin
			quiet = (k >= quiet_from && k < quiet_to);
			pick = $urandom_range(0, 99);
			if (held_q.size() != 0 && pick < 40) begin
				sel = $urandom_range(0, held_q.size() - 1);
				blk = held_q[sel];
				held_q.delete(sel);
				send(FUNC_FREE, blk.size, blk.offset);
			end else if (pick < 88) begin
				send(FUNC_ALLOC, pick_alloc_size(), $urandom_range(0, 1023));
			end else begin
				case ($urandom_range(0, 2))
					0: send(FUNC_FREE, $urandom_range(0, 2047), $urandom_range(0, 1023));
					1: begin
						// Aligned frees of arbitrary blocks: double frees and split blocks.
						sz = 1 << $urandom_range(0, $clog2(pool_pages));
						send(FUNC_FREE, sz, $urandom_range(0, pool_pages - 1) & ~(sz - 1));
					end
					default: send(FUNC_ALLOC, $urandom_range(0, 2047), $urandom_range(0, 1023));
				endcase
			end
			if (k % 150 == 149)
				drain();
		end
		quiet = 1'b0;
	endtask

	initial begin
		arst_n                = 1'b0;
		req_ch.valid          = 1'b0;
		req_ch.func           = FUNC_ALLOC;
		req_ch.request_size   = '0;
		req_ch.block_offset   = '0;
		cfg_ch.valid          = 1'b0;
		cfg_ch.pool_size_log2 = '0;
		quiet                 = 1'b0;
		pool_pages            = MAX_PAGES;
		pools_written         = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Full pool straight after reset.
		send(FUNC_ALLOC, 0, 1023);
		send(FUNC_ALLOC, 1, 0);
		send(FUNC_FREE, 2, 0);       // both halves in use, block freed as a whole
		send(FUNC_FREE, 1, 0);
		send(FUNC_FREE, 1, 1);
		send(FUNC_FREE, 1, 1);       // double free
		send(FUNC_FREE, 3, 2);       // misaligned
		send(FUNC_FREE, 2047, 1023); // larger than the pool
		send(FUNC_FREE, 512, 768);
		send(FUNC_ALLOC, 1025, 0);
		send(FUNC_ALLOC, 2047, 0);
		send(FUNC_ALLOC, 1024, 0);
		send(FUNC_ALLOC, 0, 0);
		send(FUNC_FREE, 1024, 0);
		send(FUNC_ALLOC, 512, 0);
		send(FUNC_ALLOC, 512, 0);
		send(FUNC_ALLOC, 1, 0);
		send(FUNC_FREE, 512, 512);
		send(FUNC_ALLOC, 3, 0);
		send(FUNC_ALLOC, 5, 0);
		send(FUNC_FREE, 1, 1023);
		send(FUNC_FREE, 1024, 0);

		// Single page pool.
		set_pool(0);
		send(FUNC_ALLOC, 0, 0);
		send(FUNC_ALLOC, 1, 0);
		send(FUNC_FREE, 1, 0);
		send(FUNC_FREE, 2, 0);
		send(FUNC_FREE, 1, 1);      // runs past the end of the pool
		send(FUNC_FREE, 1, 0);
		random_items(30, 0, 0);

		// Out of range value, clamped to the largest pool.
		set_pool(15);
		random_items(350, 100, 250);

		set_pool(3);
		send(FUNC_FREE, 1, 8);
		send(FUNC_FREE, 8, 0);
		random_items(120, 0, 0);

		set_pool(1);
		random_items(40, 0, 0);

		set_pool(6);
		random_items(160, 0, 0);

		set_pool(10);
		random_items(200, 0, 0);

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		$display("run covered %0d granted allocations, %0d refused for lack of space,",
			n_granted, n_refused);
		$display("%0d rejected frees, across %0d pool size writes from one page to the largest",
			n_rejected, pools_written);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
